### src/mlp_pkg.sv
// ----------------------------------------------------------------------------
// mlp_pkg: shared types and constants
// Store layout, fixed-point sizes and controller states of the perceptron.
// ----------------------------------------------------------------------------
package mlp_pkg;
  localparam int HIDDEN = 64;
  localparam int FEATURES = 11;
  localparam int OUTPUTS = 7;
  localparam int B1_BASE = HIDDEN * FEATURES;
  localparam int W2_BASE = B1_BASE + HIDDEN;
  localparam int B2_BASE = W2_BASE + OUTPUTS * HIDDEN;
  localparam int STORE_DEPTH = B2_BASE + OUTPUTS;
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int HW = $clog2(HIDDEN + 1);
  localparam int HIW = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
  localparam int FW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int OW = (OUTPUTS > 1) ? $clog2(OUTPUTS) : 1;
  localparam int ACCW = 48;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [30:0] EXP_NEG_ONE = 31'd395007542;
  localparam logic OP_WEIGHT = 1'b0;
  localparam logic OP_FEATURE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_HBIAS, S_HMAC, S_HROUND, S_TANH, S_OBIAS, S_OMAC, S_OROUND, S_EMIT
  } state_t;

  typedef struct packed {
    logic acc_bias;
    logic acc_mac;
    logic hid_mode;
    logic tanh_start;
    logic hid_write;
    logic out_load;
    logic [AW-1:0] raddr;
    logic [FW-1:0] fsel;
    logic [HIW-1:0] hsel;
    logic [HIW-1:0] hwsel;
  } dp_cmd_t;

  typedef struct packed {
    logic tanh_done;
  } dp_stat_t;
endpackage

### src/mlp_tanh.sv
// ----------------------------------------------------------------------------
// mlp_tanh: iterative fixed-point tanh
// Taylor series of e^-f, n steps of e^-1, then a restoring divide.
// ----------------------------------------------------------------------------
module mlp_tanh import mlp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] s,
  output logic               done,
  output logic signed [15:0] result
);
  typedef enum logic [2:0] {T_IDLE, T_SER, T_TDIV, T_EXP, T_DIV, T_FIN} tstate_t;
  tstate_t st;
  logic neg;
  logic [4:0] n;
  logic [11:0] f;
  logic [3:0] i;
  logic [30:0] term;
  logic signed [32:0] sum;
  logic [30:0] e;
  logic [43:0] num;
  logic [31:0] den;
  logic [43:0] quo;
  logic [32:0] rem;
  logic [5:0] cnt;
  logic [16:0] a;
  logic [42:0] tprod;
  logic [61:0] eprod;
  logic [33:0] rsh;
  logic [44:0] qr;
  logic [29:0] dvd;
  logic [3:0] drem;
  logic [2:0] dcnt;
  logic [29:0] tq;
  logic [3:0] tr;
  logic [4:0] tr5;

  assign a = s[15] ? 17'(-{s[15], s}) : 17'({1'b0, s});
  assign tprod = term * f;
  assign eprod = e * EXP_NEG_ONE + 62'(1 << 29);
  assign rsh = {rem, num[43]};
  assign qr = quo * 1'b1;

  // term divide by i: five quotient bits per cycle
  always_comb begin
    tq = dvd;
    tr = drem;
    tr5 = '0;
    for (int b = 0; b < 5; b++) begin
      tr5 = {tr, tq[29]};
      if (tr5 >= {1'b0, i}) begin
        tr = 4'(tr5 - {1'b0, i});
        tq = {tq[28:0], 1'b1};
      end else begin
        tr = tr5[3:0];
        tq = {tq[28:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= T_IDLE;
      done <= 1'b0;
    end else begin
      done <= (st == T_FIN);
      case (st)
        T_IDLE: if (start) begin
          neg <= s[15];
          n <= 5'(a[16:11]);
          f <= {a[10:0], 1'b0};
          term <= Q30_ONE;
          sum <= 33'(Q30_ONE);
          i <= 4'd1;
          st <= T_SER;
        end
        T_SER: begin
          dvd <= tprod[41:12];
          drem <= '0;
          dcnt <= '0;
          st <= T_TDIV;
        end
        T_TDIV: begin
          dvd <= tq;
          drem <= tr;
          dcnt <= dcnt + 3'd1;
          if (dcnt == 3'd5) begin
            term <= {1'b0, tq};
            sum <= i[0] ? sum - 33'(tq) : sum + 33'(tq);
            i <= i + 4'd1;
            st <= (i == 4'd12) ? T_EXP : T_SER;
          end
        end
        T_EXP: begin
          if (i == 4'd13) begin
            e <= sum[32] ? 31'd0 : (sum > 33'(Q30_ONE) ? Q30_ONE : sum[30:0]);
            i <= 4'd0;
          end else if (n != 5'd0) begin
            e <= eprod[60:30];
            n <= n - 5'd1;
          end else begin
            num <= {1'b0, Q30_ONE - e, 12'd0};
            den <= 32'(Q30_ONE) + 32'(e);
            rem <= '0;
            quo <= '0;
            cnt <= 6'd0;
            st <= T_DIV;
          end
        end
        T_DIV: begin
          num <= num << 1;
          if (rsh >= 34'(den)) begin
            rem <= 33'(rsh - 34'(den));
            quo <= {quo[42:0], 1'b1};
          end else begin
            rem <= rsh[32:0];
            quo <= {quo[42:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd43) st <= T_FIN;
        end
        T_FIN: begin
          logic [44:0] m;
          m = (34'({rem, 1'b0}) >= 34'(den)) ? qr + 45'd1 : qr;
          if (m > 45'd4096) m = 45'd4096;
          result <= neg ? -16'(m) : 16'(m);
          st <= T_IDLE;
        end
        default: st <= T_IDLE;
      endcase
    end
  end
endmodule

### src/mlp_datapath.sv
// ----------------------------------------------------------------------------
// mlp_datapath: stores and shared multiply-accumulate
// Weight memory, feature and hidden registers, accumulator, round and tanh.
// ----------------------------------------------------------------------------
module mlp_datapath import mlp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               wwrite,
  input  logic [AW-1:0]      waddr,
  input  logic               fwrite,
  input  logic [FW-1:0]      faddr,
  input  logic signed [15:0] wdata,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  output logic signed [15:0] out_value
);
  logic signed [15:0] mem [STORE_DEPTH];
  logic signed [15:0] rdata;
  logic signed [15:0] feat [FEATURES];
  logic signed [15:0] hid [HIDDEN];
  logic signed [15:0] opnd;
  logic signed [31:0] prod;
  logic signed [ACCW-1:0] acc;
  logic signed [15:0] sat;
  logic signed [ACCW-1:0] rnd;
  logic signed [15:0] tres;

  always_ff @(posedge clk) begin
    if (wwrite) mem[waddr] <= wdata;
    rdata <= mem[cmd.raddr];
  end

  always_ff @(posedge clk) begin
    if (fwrite) feat[faddr] <= wdata;
    opnd <= cmd.hid_mode ? hid[cmd.hsel] : feat[cmd.fsel];
    prod <= rdata * opnd;
  end

  assign rnd = (acc + ACCW'(2048)) >>> 12;
  assign sat = (rnd > ACCW'(32767)) ? 16'sh7fff :
               (rnd < -ACCW'(32768)) ? 16'sh8000 : 16'(rnd);

  always_ff @(posedge clk) begin
    if (cmd.acc_bias) acc <= ACCW'(rdata) <<< 12;
    else if (cmd.acc_mac) acc <= acc + ACCW'(prod);
    if (cmd.hid_write) hid[cmd.hwsel] <= tres;
    if (cmd.out_load) out_value <= sat;
  end

  mlp_tanh u_tanh (
    .clk(clk), .rst(rst), .start(cmd.tanh_start), .s(sat),
    .done(stat.tanh_done), .result(tres)
  );
endmodule

### src/mlp_ctrl.sv
// ----------------------------------------------------------------------------
// mlp_ctrl: evaluation sequencer
// Walks hidden rows then output rows, issuing addresses to the datapath.
// ----------------------------------------------------------------------------
module mlp_ctrl import mlp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [6:0]  hidden_in_use,
  input  dp_stat_t    stat,
  input  logic        out_taken,
  output dp_cmd_t     cmd,
  output logic        busy,
  output logic        out_valid,
  output logic [OW-1:0] out_idx
);
  state_t state, state_next;
  logic [HIW-1:0] j;
  logic [HW-1:0] k;
  logic [HW-1:0] hid;
  logic [2:0] pipe;
  logic [HW-1:0] kcount;

  assign hid = (7'(hidden_in_use) > 7'(HIDDEN)) ? HW'(HIDDEN) : HW'(hidden_in_use);
  assign kcount = (state == S_HMAC) ? HW'(FEATURES) : hid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      j <= '0; k <= '0; pipe <= '0; out_idx <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin j <= '0; out_idx <= '0; end
        S_HBIAS, S_OBIAS: begin k <= '0; pipe <= '0; end
        S_HMAC, S_OMAC: begin
          if (k != kcount) k <= k + 1'b1;
          pipe <= {pipe[1:0], k != kcount};
        end
        S_TANH: if (stat.tanh_done) j <= j + 1'b1;
        S_EMIT: if (out_taken) out_idx <= out_idx + 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (go) state_next = (hid == '0) ? S_OBIAS : S_HBIAS;
      S_HBIAS: state_next = S_HMAC;
      S_HMAC: if (k == kcount && pipe == '0) state_next = S_HROUND;
      S_HROUND: state_next = S_TANH;
      S_TANH: if (stat.tanh_done)
        state_next = (HW'(j) + 1'b1 == hid) ? S_OBIAS : S_HBIAS;
      S_OBIAS: state_next = S_OMAC;
      S_OMAC: if (k == kcount && pipe == '0) state_next = S_OROUND;
      S_OROUND: state_next = S_EMIT;
      S_EMIT: if (out_taken)
        state_next = (out_idx == OW'(OUTPUTS - 1)) ? S_IDLE : S_OBIAS;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.hwsel = j;
    busy = (state != S_IDLE);
    out_valid = (state == S_EMIT);
    case (state)
      S_HBIAS: cmd.raddr = AW'(B1_BASE + 32'(j));
      S_OBIAS: cmd.raddr = AW'(B2_BASE + 32'(out_idx));
      S_HMAC: begin
        cmd.raddr = AW'(32'(j) * FEATURES + 32'(k));
        cmd.fsel = FW'(k);
        cmd.acc_bias = (k == 1) && 1'b0;
        cmd.acc_mac = pipe[1];
      end
      S_OMAC: begin
        cmd.raddr = AW'(W2_BASE + 32'(out_idx) * HIDDEN + 32'(k));
        cmd.hsel = HIW'(k);
        cmd.hid_mode = 1'b1;
        cmd.acc_mac = pipe[1];
      end
      S_HROUND: cmd.tanh_start = 1'b1;
      S_TANH: cmd.hid_write = stat.tanh_done;
      S_OROUND: cmd.out_load = 1'b1;
      default: ;
    endcase
    if ((state == S_HMAC || state == S_OMAC) && k == '0 && pipe == '0)
      cmd.acc_bias = 1'b1;
  end
endmodule

### src/mlp_two_layer_tanh_forward.sv
// ----------------------------------------------------------------------------
// mlp_two_layer_tanh_forward: two-layer tanh perceptron
// Weight and feature words load the stores; the last feature word runs it.
// ----------------------------------------------------------------------------
// Load words are accepted back to back while idle. The feature word to
// the last slot starts an evaluation through the shared multiply-
// accumulate and the iterative tanh unit, which takes n <= 16 steps of
// e^-1 per hidden unit, n = floor(2|s|/4096). Input is blocked while
// evaluating. rst is synchronous; stores are not cleared, hidden_in_use
// resets to 64.
module mlp_two_layer_tanh_forward import mlp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // index[10:0], value[26:11], pad
  input  logic        s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // out_index[2:0], out_value[18:3], pad
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);
  logic [6:0] hidden_in_use;
  logic acc;
  logic [10:0] index;
  logic busy, ov;
  logic [OW-1:0] oidx;
  logic signed [15:0] oval;
  dp_cmd_t cmd;
  dp_stat_t stat;

  assign index = s_tdata[10:0];
  assign s_tready = !busy;
  assign cfg_ready = 1'b1;
  assign acc = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) hidden_in_use <= 7'd64;
    else if (cfg_valid) hidden_in_use <= cfg_data;
  end

  mlp_datapath u_dp (
    .clk(clk), .rst(rst),
    .wwrite(acc && s_tuser == OP_WEIGHT && 32'(index) < STORE_DEPTH),
    .waddr(AW'(index)),
    .fwrite(acc && s_tuser == OP_FEATURE && 32'(index) < FEATURES),
    .faddr(FW'(index)),
    .wdata(s_tdata[26:11]), .cmd(cmd), .stat(stat), .out_value(oval)
  );

  mlp_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .go(acc && s_tuser == OP_FEATURE && 32'(index) == FEATURES - 1),
    .hidden_in_use(hidden_in_use), .stat(stat), .out_taken(m_tready),
    .cmd(cmd), .busy(busy), .out_valid(ov), .out_idx(oidx)
  );

  assign m_tvalid = ov;
  assign m_tdata = {5'd0, oval, 3'(oidx)};
  assign m_tlast = (32'(oidx) == OUTPUTS - 1);
endmodule
